@@ hdl/gbts_pkg.sv @@
// shared types and constants of the gap buffer text store
package gbts_pkg;

  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = ADDR_W + 1;
  localparam int unsigned CHAR_W   = 8;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_MOVE   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ERASE,
    S_READ,
    S_MOVE,
    S_DONE
  } state_t;

  // one write port and one read port, used in the same cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ hdl/gbts_ram.sv @@
// text byte memory, one write and one registered read per cycle
module gbts_ram (
  input  logic                            clk,
  input  gbts_pkg::mem_req_t              req,
  output logic [gbts_pkg::CHAR_W-1:0]     rdata
);

  logic [gbts_pkg::CHAR_W-1:0] mem [gbts_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hdl/gap_buffer_text_store_top.sv @@
// gap buffer text store: sequencer, gap pointers and the text memory
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------
//  command   | start / busy     | action, char_in, position
//  result    | done (strobe)    | read_char, status, text_length, cursor
//
// a command transfer happens at a rising edge with start high and busy low
// insert goes from the execute state straight to done; erase and read pass
// through one more state for the registered memory read, unless refused; a
// move loops in the copy state, as the copy loop moves one byte a cycle through
// the single memory port pair
// the result is shown for the done cycle only; the next command may be
// taken at the edge that ends it, so there is no result stall
// rst clears the sequencer and the gap pointers; memory contents are
// undefined until written and need no clearing pass
module gap_buffer_text_store_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic [gbts_pkg::CHAR_W-1:0]     char_in,
  input  logic [gbts_pkg::POS_W-1:0]      position,
  output logic                            done,
  output logic [gbts_pkg::CHAR_W-1:0]     read_char,
  output logic [1:0]                      status,
  output logic [gbts_pkg::POS_W-1:0]      text_length,
  output logic [gbts_pkg::POS_W-1:0]      cursor
);

  localparam int unsigned AW = gbts_pkg::ADDR_W;
  localparam int unsigned PW = gbts_pkg::POS_W;

  gbts_pkg::state_t  state, state_next;
  gbts_pkg::action_t act;
  gbts_pkg::mem_req_t req;

  logic [gbts_pkg::CHAR_W-1:0] ch;
  logic [PW-1:0]               pos;
  logic [PW-1:0]               gap_start;   // cursor, first gap cell
  logic [AW-1:0]               gap_end_last; // last gap cell
  logic [AW-1:0]               count;        // bytes still to copy
  logic                        fwd;          // gap moves towards the end
  logic [gbts_pkg::CHAR_W-1:0] rdata;

  logic [PW-1:0] len;
  logic [PW-1:0] target;
  logic          over;
  logic          full;
  logic          tgt_fwd;
  logic [PW-1:0] tgt_diff;
  logic [PW-1:0] gap_len;
  logic [PW-1:0] rd_idx;
  logic          transfer;

  // text length = cells before the gap plus cells after it
  assign len      = gap_start + {1'b0, ~gap_end_last};
  assign full     = gap_start >= {1'b0, gap_end_last};
  assign over     = pos > len;
  assign target   = over ? len : pos;
  assign tgt_fwd  = target > gap_start;
  assign tgt_diff = tgt_fwd ? (target - gap_start) : (gap_start - target);
  assign gap_len  = {1'b0, gap_end_last} + PW'(1) - gap_start;
  // logical position to physical cell, skipping the gap
  assign rd_idx   = (pos < gap_start) ? pos : (pos + gap_len);

  assign transfer    = start && !busy;
  assign cursor      = gap_start;
  assign text_length = len;

  gbts_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gbts_pkg::S_IDLE, gbts_pkg::S_DONE: begin
        state_next = start ? gbts_pkg::S_EXEC : gbts_pkg::S_IDLE;
      end
      gbts_pkg::S_EXEC: begin
        case (act)
          gbts_pkg::ACT_INSERT: state_next = gbts_pkg::S_DONE;
          gbts_pkg::ACT_ERASE: begin
            state_next = (gap_start == '0) ? gbts_pkg::S_DONE : gbts_pkg::S_ERASE;
          end
          gbts_pkg::ACT_MOVE: begin
            state_next = (target == gap_start) ? gbts_pkg::S_DONE : gbts_pkg::S_MOVE;
          end
          default: begin
            state_next = (pos >= len) ? gbts_pkg::S_DONE : gbts_pkg::S_READ;
          end
        endcase
      end
      gbts_pkg::S_ERASE, gbts_pkg::S_READ: state_next = gbts_pkg::S_DONE;
      gbts_pkg::S_MOVE: begin
        state_next = (count == AW'(1)) ? gbts_pkg::S_DONE : gbts_pkg::S_MOVE;
      end
      default: state_next = gbts_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: memory requests and handshake
  always_comb begin
    req  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      gbts_pkg::S_IDLE: busy = 1'b0;
      gbts_pkg::S_DONE: begin
        busy = 1'b0;
        done = 1'b1;
      end
      gbts_pkg::S_EXEC: begin
        case (act)
          gbts_pkg::ACT_INSERT: begin
            req.we    = !full;
            req.waddr = gap_start[AW-1:0];
            req.wdata = ch;
          end
          gbts_pkg::ACT_ERASE: begin
            req.re    = gap_start != '0;
            req.raddr = AW'(gap_start - PW'(1));
          end
          gbts_pkg::ACT_MOVE: begin
            // first source byte: just past the gap, or just before it
            req.re    = target != gap_start;
            req.raddr = tgt_fwd ? (gap_end_last + AW'(1)) : AW'(gap_start - PW'(1));
          end
          default: begin
            req.re    = pos < len;
            req.raddr = rd_idx[AW-1:0];
          end
        endcase
      end
      gbts_pkg::S_MOVE: begin
        // write the byte fetched last cycle, fetch the next one
        req.we    = 1'b1;
        req.waddr = fwd ? gap_start[AW-1:0] : gap_end_last;
        req.wdata = rdata;
        req.re    = count != AW'(1);
        req.raddr = fwd ? (gap_end_last + AW'(2)) : AW'(gap_start - PW'(2));
      end
      default: ;
    endcase
  end

  // sequencer state and gap pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gbts_pkg::S_IDLE;
      gap_start    <= '0;
      gap_end_last <= '1;
    end else begin
      state <= state_next;
      case (state)
        gbts_pkg::S_EXEC: begin
          if (act == gbts_pkg::ACT_INSERT && !full) begin
            gap_start <= gap_start + PW'(1);
          end
        end
        gbts_pkg::S_ERASE: begin
          // a byte with its top bit set takes the byte before it with it
          if (rdata[gbts_pkg::CHAR_W-1] && gap_start >= PW'(2)) begin
            gap_start <= gap_start - PW'(2);
          end else begin
            gap_start <= gap_start - PW'(1);
          end
        end
        gbts_pkg::S_MOVE: begin
          if (fwd) begin
            gap_start    <= gap_start + PW'(1);
            gap_end_last <= gap_end_last + AW'(1);
          end else begin
            gap_start    <= gap_start - PW'(1);
            gap_end_last <= gap_end_last - AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // command payload, copy counter and result fields
  always_ff @(posedge clk) begin
    if (transfer) begin
      act       <= gbts_pkg::action_t'(action);
      ch        <= char_in;
      pos       <= position;
      read_char <= '0;
      status    <= gbts_pkg::STAT_OK;
    end else begin
      case (state)
        gbts_pkg::S_EXEC: begin
          count <= tgt_diff[AW-1:0];
          fwd   <= tgt_fwd;
          case (act)
            gbts_pkg::ACT_INSERT: if (full) status <= gbts_pkg::STAT_FULL;
            gbts_pkg::ACT_ERASE: if (gap_start == '0) status <= gbts_pkg::STAT_EMPTY;
            gbts_pkg::ACT_MOVE: if (over) status <= gbts_pkg::STAT_RANGE;
            default: if (pos >= len) status <= gbts_pkg::STAT_RANGE;
          endcase
        end
        gbts_pkg::S_READ: read_char <= rdata;
        gbts_pkg::S_MOVE: count <= count - AW'(1);
        default: ;
      endcase
    end
  end

  // a taken command starts work and never shows a stale result next cycle
  a_transfer_busy: assert property (@(posedge clk) disable iff (rst)
    transfer |=> busy && !done)
    else $error("command transfer not followed by busy");

  // the gap always keeps at least one cell
  a_gap_kept: assert property (@(posedge clk) disable iff (rst)
    gap_start <= {1'b0, gap_end_last})
    else $error("gap collapsed");

  // only a read returns a non-zero byte
  a_read_char_zero: assert property (@(posedge clk) disable iff (rst)
    done && act != gbts_pkg::ACT_READ |-> read_char == '0)
    else $error("read_char non-zero on a non-read result");

  // a failed read returns zero
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == gbts_pkg::STAT_RANGE && act == gbts_pkg::ACT_READ
      |-> read_char == '0)
    else $error("read_char non-zero on an out of range read");

endmodule

@@ dv/gap_buffer_text_store_checker.sv @@
// result predictor and checker for the gap buffer text store
`timescale 1ns / 100ps
module gap_buffer_text_store_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  action,
  input  logic [gbts_pkg::CHAR_W-1:0] char_in,
  input  logic [gbts_pkg::POS_W-1:0]  position,
  input  logic                        done,
  input  logic [gbts_pkg::CHAR_W-1:0] read_char,
  input  logic [1:0]                  status,
  input  logic [gbts_pkg::POS_W-1:0]  text_length,
  input  logic [gbts_pkg::POS_W-1:0]  cursor,
  output int                          errors,
  output int                          pending
);

  typedef struct {
    logic [gbts_pkg::CHAR_W-1:0] read_char;
    gbts_pkg::status_t           status;
    logic [gbts_pkg::POS_W-1:0]  text_length;
    logic [gbts_pkg::POS_W-1:0]  cursor;
  } edit_result_t;

  logic [gbts_pkg::CHAR_W-1:0] text_mem [gbts_pkg::CAPACITY];
  int unsigned       gap_lo;   // first gap cell, the cursor
  int unsigned       gap_hi;   // last gap cell
  edit_result_t      expected_edits [$];

  task automatic predict_edit(input gbts_pkg::action_t act,
                              input logic [gbts_pkg::CHAR_W-1:0] ch,
                              input logic [gbts_pkg::POS_W-1:0] pos);
    int unsigned  len;
    int unsigned  target;
    int unsigned  n;
    int unsigned  gap_cells;
    edit_result_t r;
    len         = gap_lo + (gbts_pkg::CAPACITY - 1 - gap_hi);
    target      = pos;
    r.read_char = '0;
    r.status    = gbts_pkg::STAT_OK;
    case (act)
      gbts_pkg::ACT_INSERT: begin
        if (gap_lo >= gap_hi) begin
          r.status = gbts_pkg::STAT_FULL;
        end else begin
          text_mem[gap_lo] = ch;
          gap_lo++;
        end
      end
      gbts_pkg::ACT_ERASE: begin
        if (gap_lo == 0) begin
          r.status = gbts_pkg::STAT_EMPTY;
        end else if (text_mem[gap_lo-1][gbts_pkg::CHAR_W-1] && gap_lo >= 2) begin
          gap_lo -= 2;
        end else begin
          gap_lo -= 1;
        end
      end
      gbts_pkg::ACT_MOVE: begin
        if (target > len) begin
          target   = len;
          r.status = gbts_pkg::STAT_RANGE;
        end
        if (target > gap_lo) begin
          n = target - gap_lo;
          for (int unsigned i = 0; i < n; i++)
            text_mem[gap_lo + i] = text_mem[gap_hi + 1 + i];
          gap_hi += n;
        end else if (target < gap_lo) begin
          n         = gap_lo - target;
          gap_cells = gap_hi + 1 - gap_lo;
          for (int unsigned i = n; i > 0; i--)
            text_mem[target + gap_cells + i - 1] = text_mem[target + i - 1];
          gap_hi -= n;
        end
        gap_lo = target;
      end
      gbts_pkg::ACT_READ: begin
        if (target >= len) begin
          r.status = gbts_pkg::STAT_RANGE;
        end else begin
          r.read_char = text_mem[(target < gap_lo) ? target : target + gap_hi + 1 - gap_lo];
        end
      end
    endcase
    r.text_length = gbts_pkg::POS_W'(gap_lo + (gbts_pkg::CAPACITY - 1 - gap_hi));
    r.cursor      = gbts_pkg::POS_W'(gap_lo);
    expected_edits.push_back(r);
  endtask

  always @(posedge clk) begin
    edit_result_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      expected_edits.delete();
      gap_lo = 0;
      gap_hi = gbts_pkg::CAPACITY - 1;
      errors  <= 0;
      pending <= 0;
    end else begin
      // the result goes first, a new command may be taken at the same edge
      if (done) begin
        if (expected_edits.size() == 0) begin
          bad++;
          $display("%0t: result with nothing expected (status %0d, length %0d, cursor %0d)",
                   $time, status, text_length, cursor);
        end else begin
          want = expected_edits.pop_front();
          if (read_char !== want.read_char) begin
            bad++;
            $display("%0t: read_char expected %02h, got %02h",
                     $time, want.read_char, read_char);
          end
          if (status !== want.status) begin
            bad++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          end
          if (text_length !== want.text_length) begin
            bad++;
            $display("%0t: text_length expected %0d, got %0d",
                     $time, want.text_length, text_length);
          end
          if (cursor !== want.cursor) begin
            bad++;
            $display("%0t: cursor expected %0d, got %0d", $time, want.cursor, cursor);
          end
        end
      end
      if (start && !busy) predict_edit(gbts_pkg::action_t'(action), char_in, position);
      errors  <= errors + bad;
      pending <= expected_edits.size();
    end
  end

endmodule

@@ dv/gap_buffer_text_store_top_tb.sv @@
// testbench top: command stimulus for the gap buffer text store and the verdict
`timescale 1ns / 100ps
module gap_buffer_text_store_top_tb;

  // every input known from time zero
  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           start    = 1'b0;
  logic [1:0]                     action   = gbts_pkg::ACT_INSERT;
  logic [gbts_pkg::CHAR_W-1:0]    char_in  = '0;
  logic [gbts_pkg::POS_W-1:0]     position = '0;
  logic                           busy;
  logic                           done;
  logic [gbts_pkg::CHAR_W-1:0]    read_char;
  logic [1:0]                     status;
  logic [gbts_pkg::POS_W-1:0]     text_length;
  logic [gbts_pkg::POS_W-1:0]     cursor;
  int                             errors;
  int                             pending;

  // text length as last reported by the block, only used to shape stimulus
  int unsigned          last_len = 0;
  // sender gaps on or off, off for one long stretch of the random part
  bit                   gaps_on  = 1'b1;

  gap_buffer_text_store_top dut (.*);

  gap_buffer_text_store_checker edit_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (done) last_len <= text_length;
  end

  // one command transfer; returns at the edge where start high met busy low
  task automatic issue_command(input gbts_pkg::action_t act,
                               input logic [gbts_pkg::CHAR_W-1:0] ch,
                               input logic [gbts_pkg::POS_W-1:0] pos);
    int unsigned idle;
    idle = 0;
    if (gaps_on && $urandom_range(0, 99) < 10) idle = $urandom_range(1, 4);
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    // start stays high between back-to-back transfers, only the payload changes
    start    <= 1'b1;
    action   <= act;
    char_in  <= ch;
    position <= pos;
    do @(posedge clk); while (busy);
  endtask

  // wait until every expected result has come back; pending is a registered count
  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly just around the text, now and then anywhere in the 13-bit field
  function automatic logic [gbts_pkg::POS_W-1:0] pick_position(input int unsigned len);
    if ($urandom_range(0, 99) < 80) return gbts_pkg::POS_W'($urandom_range(0, len + 1));
    return gbts_pkg::POS_W'($urandom_range(0, (1 << gbts_pkg::POS_W) - 1));
  endfunction

  initial begin
    gbts_pkg::action_t act;
    int unsigned       sel;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-buffer corners first
    issue_command(gbts_pkg::ACT_ERASE, 8'h00, '0);   // erase with nothing before the cursor
    issue_command(gbts_pkg::ACT_READ,  8'hff, '0);   // read of an empty text
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, '1);   // move past end, clamped to zero
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, '0);
    issue_command(gbts_pkg::ACT_INSERT, 8'h00, '0);
    issue_command(gbts_pkg::ACT_INSERT, 8'hff, '1);
    issue_command(gbts_pkg::ACT_INSERT, 8'h41, '0);
    issue_command(gbts_pkg::ACT_INSERT, 8'h80, '0);
    issue_command(gbts_pkg::ACT_READ,  8'h00, gbts_pkg::POS_W'(0));
    issue_command(gbts_pkg::ACT_READ,  8'h00, gbts_pkg::POS_W'(3));
    issue_command(gbts_pkg::ACT_READ,  8'h00, gbts_pkg::POS_W'(4));    // just past the end
    issue_command(gbts_pkg::ACT_READ,  8'h00, gbts_pkg::POS_W'(4096)); // top position bit
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, gbts_pkg::POS_W'(1));    // gap back over three
    issue_command(gbts_pkg::ACT_INSERT, 8'h7f, '0);
    issue_command(gbts_pkg::ACT_READ,  8'h00, gbts_pkg::POS_W'(4));    // beyond the gap
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, gbts_pkg::POS_W'(5));    // gap forwards to end
    issue_command(gbts_pkg::ACT_ERASE, 8'h00, '0);   // top bit set: two bytes go
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, gbts_pkg::POS_W'(1));
    issue_command(gbts_pkg::ACT_ERASE, 8'h00, '0);   // plain byte: one goes
    issue_command(gbts_pkg::ACT_INSERT, 8'hc3, '0);
    issue_command(gbts_pkg::ACT_ERASE, 8'h00, '0);   // top-bit byte alone before cursor
    issue_command(gbts_pkg::ACT_INSERT, 8'haa, '0);
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, '0);
    issue_command(gbts_pkg::ACT_READ,  8'h00, '0);
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, gbts_pkg::POS_W'(4096)); // clamped, status range

    // random part: length kept to a few hundred bytes so moves stay short
    for (int k = 0; k < 600; k++) begin
      gaps_on = !(k >= 200 && k < 350);
      sel     = $urandom_range(0, 99);
      if (last_len > 300)  act = gbts_pkg::ACT_ERASE;
      else if (sel < 35)   act = gbts_pkg::ACT_INSERT;
      else if (sel < 55)   act = gbts_pkg::ACT_ERASE;
      else if (sel < 75)   act = gbts_pkg::ACT_MOVE;
      else                 act = gbts_pkg::ACT_READ;
      issue_command(act, gbts_pkg::CHAR_W'($urandom()), pick_position(last_len));
    end
    gaps_on = 1'b1;

    // closing corners: long moves both ways, reads at and past the edges of the text
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, '0);
    issue_command(gbts_pkg::ACT_READ,  8'h00, '0);
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, gbts_pkg::POS_W'(gbts_pkg::CAPACITY));
    issue_command(gbts_pkg::ACT_READ,  8'h00, gbts_pkg::POS_W'(gbts_pkg::CAPACITY - 1));
    issue_command(gbts_pkg::ACT_READ,  8'h00, '1);
    issue_command(gbts_pkg::ACT_ERASE, 8'h00, '0);
    issue_command(gbts_pkg::ACT_INSERT, 8'h3c, '0);
    issue_command(gbts_pkg::ACT_INSERT, 8'hc3, '0);
    issue_command(gbts_pkg::ACT_ERASE, 8'h00, '0);
    issue_command(gbts_pkg::ACT_MOVE,  8'h00, gbts_pkg::POS_W'(gbts_pkg::CAPACITY / 2));
    issue_command(gbts_pkg::ACT_INSERT, 8'h11, '0);
    issue_command(gbts_pkg::ACT_READ,  8'h00, '0);
    start <= 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** gap_buffer_text_store_top: PASSED **");
    end else begin
      $display("** gap_buffer_text_store_top: FAILED **");
    end
    $finish;
  end

  // safety net: a run still going at this time limit is reported as failed
  initial begin
    #(15_000_000);
    $display("** gap_buffer_text_store_top: FAILED **");
    $finish;
  end

endmodule
